FILE: src/cepm_pkg.sv
// Shared constants and types for the color ellipse pixel masker.
package cepm_pkg;

  localparam int NUM_STAGES = 7;

  localparam logic [14:0] CX_R = 15'd24445;
  localparam logic [14:0] CX_G = 15'd21692;
  localparam logic [14:0] CX_B = 15'd2753;
  localparam logic [14:0] CY_R = 15'd10945;
  localparam logic [14:0] CY_G = 15'd15729;
  localparam logic [14:0] CY_B = 15'd26673;
  localparam logic [14:0] CZ_R = 15'd18874;
  localparam logic [14:0] CZ_G = 15'd18907;
  localparam logic [14:0] CZ_B = 15'd18973;

  localparam int unsigned CZ_SUM = 32'(CZ_R) + 32'(CZ_G) + 32'(CZ_B);
  localparam logic [23:0] RZ_DEN = 24'(CZ_SUM * 255);
  localparam logic [22:0] RZ_HALF = 23'(RZ_DEN / 2);
  localparam int RZ_SHIFT = 24;
  localparam logic [16:0] RZ_RECIP = 17'((64'd1 << (RZ_SHIFT + 16)) / 64'(RZ_DEN));

  localparam logic [7:0] CHROMA_BIAS = 8'd127;
  localparam logic [9:0] GRAY_RECIP = 10'd683;

  localparam logic [15:0] RST_RADIUS_X_LO = 16'd4345;
  localparam logic [15:0] RST_RADIUS_X_HI = 16'd5793;
  localparam logic [15:0] RST_RADIUS_Y_LO = 16'd6901;
  localparam logic [15:0] RST_RADIUS_Y_HI = 16'd10990;

  typedef enum logic [1:0] {
    REG_RADIUS_X_LO,
    REG_RADIUS_X_HI,
    REG_RADIUS_Y_LO,
    REG_RADIUS_Y_HI
  } cepm_reg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } cepm_pipe_t;

endpackage

FILE: src/color_ellipse_pixel_masker_unit.sv
// Top level of the color ellipse pixel masker: stream pipeline and radius registers.
// One pixel is taken per clock while the output is not stalled; its gray level and mask
// bit come out of the last of the seven register stages (chroma and brightness dot
// products, reciprocal divisions, brightness correction, radius interpolation,
// squaring, cross products, ellipse compare), each of which holds its pixel while the
// stage after it is full and stalled. Radius registers sit on the APB port at byte
// addresses 0, 4, 8 and 12; they must be written while idle (the block does not enforce it).
module color_ellipse_pixel_masker_unit
  import cepm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // gray[7:0], mask_bit[8], zero[15:9]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] radius_x_lo;
  logic [15:0] radius_x_hi;
  logic [15:0] radius_y_lo;
  logic [15:0] radius_y_hi;

  cepm_pipe_t pipe;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x_lo <= RST_RADIUS_X_LO;
      radius_x_hi <= RST_RADIUS_X_HI;
      radius_y_lo <= RST_RADIUS_Y_LO;
      radius_y_hi <= RST_RADIUS_Y_HI;
    end else if (psel && penable && pwrite && pready) begin
      case (cepm_reg_t'(paddr[3:2]))
        REG_RADIUS_X_LO: radius_x_lo <= pwdata[15:0];
        REG_RADIUS_X_HI: radius_x_hi <= pwdata[15:0];
        REG_RADIUS_Y_LO: radius_y_lo <= pwdata[15:0];
        REG_RADIUS_Y_HI: radius_y_hi <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cepm_reg_t'(paddr[3:2]))
      REG_RADIUS_X_LO: prdata = {16'b0, radius_x_lo};
      REG_RADIUS_X_HI: prdata = {16'b0, radius_x_hi};
      REG_RADIUS_Y_LO: prdata = {16'b0, radius_y_lo};
      REG_RADIUS_Y_HI: prdata = {16'b0, radius_y_hi};
      default: prdata = '0;
    endcase
  end

  cepm_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .pipe      (pipe)
  );

  // stage 1: dot products and gray level
  logic [7:0]  red, green, blue;
  logic [22:0] cx_pos, cx_neg, cy_pos, cy_neg;
  logic [22:0] cx_num, cy_num;
  logic [23:0] z;
  logic [9:0]  gsum;
  logic [20:0] gprod;

  logic [22:0] s1_cx_num, s1_cy_num;
  logic [23:0] s1_z;
  logic [7:0]  s1_gray;

  always_comb begin
    red = s_axis_tdata[7:0];
    green = s_axis_tdata[15:8];
    blue = s_axis_tdata[23:16];
    cx_pos = 23'(CX_G) * 23'(green) + 23'(CX_B) * 23'(blue);
    cx_neg = 23'(CX_R) * 23'(red);
    cy_pos = 23'(CY_R) * 23'(red) + 23'(CY_G) * 23'(green);
    cy_neg = 23'(CY_B) * 23'(blue);
    cx_num = ((cx_pos >= cx_neg) ? (cx_pos - cx_neg) : (cx_neg - cx_pos))
             + 23'(CHROMA_BIAS);
    cy_num = ((cy_pos >= cy_neg) ? (cy_pos - cy_neg) : (cy_neg - cy_pos))
             + 23'(CHROMA_BIAS);
    z = 24'(CZ_R) * 24'(red) + 24'(CZ_G) * 24'(green) + 24'(CZ_B) * 24'(blue);
    gsum = 10'(red) + 10'(green) + 10'(blue) + 10'd1;
    gprod = 21'(gsum) * 21'(GRAY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (pipe.load[0]) begin
      s1_cx_num <= cx_num;
      s1_cy_num <= cy_num;
      s1_z <= z;
      s1_gray <= gprod[18:11];
    end
  end

  // stage 2: chroma division and brightness quotient estimate
  logic [14:0] cx, cy;
  logic [40:0] zprod;

  logic [14:0] s2_cx, s2_cy;
  logic [16:0] s2_q0;
  logic [23:0] s2_z;
  logic [7:0]  s2_gray;

  cepm_div255 u_div_cx (.num(s1_cx_num), .quo(cx));
  cepm_div255 u_div_cy (.num(s1_cy_num), .quo(cy));

  assign zprod = 41'(s1_z) * 41'(RZ_RECIP);

  always_ff @(posedge clk) begin
    if (pipe.load[1]) begin
      s2_cx <= cx;
      s2_cy <= cy;
      s2_q0 <= zprod[40:24];
      s2_z <= s1_z;
      s2_gray <= s1_gray;
    end
  end

  // stage 3: correct brightness quotient
  logic [39:0] znum;
  logic [40:0] zback, zrem;
  logic [16:0] rz_next;

  logic [16:0] s3_rz;
  logic [14:0] s3_cx, s3_cy;
  logic [7:0]  s3_gray;

  always_comb begin
    znum = {s2_z, 16'b0} + 40'(RZ_HALF);
    zback = 41'(s2_q0) * 41'(RZ_DEN);
    zrem = 41'(znum) - zback;
    if (zrem >= 41'({RZ_DEN, 1'b0})) begin
      rz_next = s2_q0 + 17'd2;
    end else if (zrem >= 41'(RZ_DEN)) begin
      rz_next = s2_q0 + 17'd1;
    end else begin
      rz_next = s2_q0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.load[2]) begin
      s3_rz <= rz_next;
      s3_cx <= s2_cx;
      s3_cy <= s2_cy;
      s3_gray <= s2_gray;
    end
  end

  // stage 4: radius interpolation
  logic [15:0] rx, ry;

  logic [15:0] s4_rx, s4_ry;
  logic [14:0] s4_cx, s4_cy;
  logic [7:0]  s4_gray;

  cepm_interp u_interp_x (.lo(radius_x_lo), .hi(radius_x_hi), .rz(s3_rz), .rad(rx));
  cepm_interp u_interp_y (.lo(radius_y_lo), .hi(radius_y_hi), .rz(s3_rz), .rad(ry));

  always_ff @(posedge clk) begin
    if (pipe.load[3]) begin
      s4_rx <= rx;
      s4_ry <= ry;
      s4_cx <= s3_cx;
      s4_cy <= s3_cy;
      s4_gray <= s3_gray;
    end
  end

  // stage 5: squares
  logic [31:0] s5_rx2, s5_ry2;
  logic [29:0] s5_cx2, s5_cy2;
  logic [7:0]  s5_gray;

  always_ff @(posedge clk) begin
    if (pipe.load[4]) begin
      s5_rx2 <= 32'(s4_rx) * 32'(s4_rx);
      s5_ry2 <= 32'(s4_ry) * 32'(s4_ry);
      s5_cx2 <= 30'(s4_cx) * 30'(s4_cx);
      s5_cy2 <= 30'(s4_cy) * 30'(s4_cy);
      s5_gray <= s4_gray;
    end
  end

  // stage 6: cross products
  logic [61:0] s6_a, s6_b;
  logic [63:0] s6_c;
  logic [7:0]  s6_gray;

  always_ff @(posedge clk) begin
    if (pipe.load[5]) begin
      s6_a <= 62'(s5_cx2) * 62'(s5_ry2);
      s6_b <= 62'(s5_cy2) * 62'(s5_rx2);
      s6_c <= 64'(s5_rx2) * 64'(s5_ry2);
      s6_gray <= s5_gray;
    end
  end

  // stage 7: ellipse compare
  logic [62:0] lhs;
  logic [61:0] rhs;
  logic        s7_mask;
  logic [7:0]  s7_gray;

  assign lhs = 63'(s6_a) + 63'(s6_b);
  assign rhs = s6_c[63:2];

  always_ff @(posedge clk) begin
    if (pipe.load[6]) begin
      s7_mask <= ~(lhs > 63'(rhs));
      s7_gray <= s6_gray;
    end
  end

  assign m_axis_tvalid = pipe.valid[NUM_STAGES-1];
  assign m_axis_tdata = {7'b0, s7_mask, s7_gray};

endmodule

FILE: src/cepm_div255.sv
// Rounded chroma magnitude: quotient of a biased value by 255 via reciprocal.
module cepm_div255
  import cepm_pkg::*;
(
  input  logic [22:0] num,
  output logic [14:0] quo
);

  logic [31:0] scaled;
  logic [15:0] q0;
  logic [22:0] back;
  logic [22:0] rem;

  always_comb begin
    scaled = ({9'b0, num} << 8) + {9'b0, num};
    q0 = scaled[31:16];
    back = 23'({q0, 8'b0} - {8'b0, q0});
    rem = num - back;
    if (rem >= 23'd255) begin
      quo = q0[14:0] + 15'd1;
    end else begin
      quo = q0[14:0];
    end
  end

endmodule

FILE: src/cepm_interp.sv
// Linear interpolation of one ellipse radius by brightness.
module cepm_interp
  import cepm_pkg::*;
(
  input  logic [15:0] lo,
  input  logic [15:0] hi,
  input  logic [16:0] rz,
  output logic [15:0] rad
);

  logic        up;
  logic [15:0] diff;
  logic [33:0] prod;
  logic [16:0] corr;
  logic [16:0] sum;

  always_comb begin
    up = (hi >= lo);
    diff = up ? (hi - lo) : (lo - hi);
    prod = 34'(diff) * 34'(rz) + 34'd32768;
    corr = prod[32:16];
    sum = up ? (17'(lo) + corr) : (17'(lo) - corr);
    rad = sum[15:0];
  end

endmodule

FILE: src/cepm_pipe_ctrl.sv
// Valid bits and per-stage load enables of the pixel pipeline.
module cepm_pipe_ctrl
  import cepm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  output logic       in_ready,
  output cepm_pipe_t pipe
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = ~valid[NUM_STAGES-1] | out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = ~valid[i] | load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_ready = load[0];
  assign pipe.load = load;
  assign pipe.valid = valid;

endmodule
